[hw/rtl/c6502_pkg.sv]
// Package for the 6502 execute unit: opcodes, flag positions and decode masks.
package c6502_pkg;

  localparam int DATA_W   = 8;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 56;
  localparam int FLAG_W   = 7;

  // flag register bit positions (N V B D I Z C)
  localparam int FL_N = 6;
  localparam int FL_V = 5;
  localparam int FL_B = 4;
  localparam int FL_D = 3;
  localparam int FL_I = 2;
  localparam int FL_Z = 1;
  localparam int FL_C = 0;

  localparam logic [DATA_W-1:0] SP_RESET   = 8'hFD;
  localparam logic [FLAG_W-1:0] FLAG_RESET = 7'b000_0100;
  localparam logic [DATA_W-1:0] PUSH_BITS  = 8'h30;

  // single-byte opcodes
  localparam logic [7:0] OP_PHP = 8'h08;
  localparam logic [7:0] OP_PHA = 8'h48;
  localparam logic [7:0] OP_PLP = 8'h28;
  localparam logic [7:0] OP_PLA = 8'h68;
  localparam logic [7:0] OP_DEY = 8'h88;
  localparam logic [7:0] OP_INY = 8'hC8;
  localparam logic [7:0] OP_DEX = 8'hCA;
  localparam logic [7:0] OP_INX = 8'hE8;
  localparam logic [7:0] OP_TAY = 8'hA8;
  localparam logic [7:0] OP_TYA = 8'h98;
  localparam logic [7:0] OP_TAX = 8'hAA;
  localparam logic [7:0] OP_TXA = 8'h8A;
  localparam logic [7:0] OP_TSX = 8'hBA;
  localparam logic [7:0] OP_TXS = 8'h9A;
  localparam logic [7:0] OP_CLC = 8'h18;
  localparam logic [7:0] OP_SEC = 8'h38;
  localparam logic [7:0] OP_CLI = 8'h58;
  localparam logic [7:0] OP_SEI = 8'h78;
  localparam logic [7:0] OP_CLV = 8'hB8;
  localparam logic [7:0] OP_CLD = 8'hD8;
  localparam logic [7:0] OP_SED = 8'hF8;
  localparam logic [7:0] OP_BIT_IMM = 8'h89;

  // branch opcodes: low five bits
  localparam logic [4:0] BRANCH_LO = 5'h10;

  // cc groups
  localparam logic [1:0] CC_0 = 2'd0;
  localparam logic [1:0] CC_1 = 2'd1;
  localparam logic [1:0] CC_2 = 2'd2;

  // aaa codes, group one
  localparam logic [2:0] G1_ORA = 3'd0;
  localparam logic [2:0] G1_AND = 3'd1;
  localparam logic [2:0] G1_EOR = 3'd2;
  localparam logic [2:0] G1_ADC = 3'd3;
  localparam logic [2:0] G1_STA = 3'd4;
  localparam logic [2:0] G1_LDA = 3'd5;
  localparam logic [2:0] G1_CMP = 3'd6;
  localparam logic [2:0] G1_SBC = 3'd7;

  localparam logic [2:0] AAA_BIT = 3'd1;
  localparam logic [2:0] AAA_ST  = 3'd4;
  localparam logic [2:0] AAA_LD  = 3'd5;
  localparam logic [2:0] AAA_DEC = 3'd6;
  localparam logic [2:0] AAA_INC = 3'd7;
  localparam logic [2:0] BBB_ACC = 3'd2;

  // addressing-mode masks, indexed by bbb
  localparam logic [7:0] M_SHIFT = 8'hAE;
  localparam logic [7:0] M_INCDEC = 8'hAA;
  localparam logic [7:0] M_LOAD  = 8'hAB;
  localparam logic [7:0] M_STORE = 8'h2A;
  localparam logic [7:0] M_BIT   = 8'h0A;
  localparam logic [7:0] M_CPXY  = 8'h0B;

endpackage

[hw/rtl/cpu6502_execute_unit.sv]
// Execute stage of a binary-only 6502: register file, ALU and result register.
//
// One instruction per beat is accepted every cycle while the output is not stalled. A beat
// is caught in an input register and executed there against A, X, Y, SP and the flags.
// Its result and the new register values are loaded together into an output register
// once that register is free, and out_tvalid rises from that register. The register
// update loop sets the rate; the output register lets the next beat enter while a
// result still waits.
module cpu6502_execute_unit
  import c6502_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // opcode[7:0], mem_data[15:8]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // acc_out, x_out, y_out, sp_out, status_out,
                                       // store_data, store_valid[48], branch_taken[49]
);

  logic              s1_valid_r;
  logic [7:0]        op_r;
  logic [7:0]        mem_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [7:0]        acc_r, x_r, y_r, sp_r;
  logic [FLAG_W-1:0] flag_r;
  logic [7:0]        acc_nxt, x_nxt, y_nxt, sp_nxt;
  logic [FLAG_W-1:0] flag_nxt;
  logic [7:0]        st;
  logic              sv;
  logic              br;

  logic              out_load;
  logic              in_fire;

  function automatic logic [8:0] shift_op(input logic [1:0] kind, input logic [7:0] v,
                                          input logic cin);
    logic [8:0] res;
    begin
      case (kind)
        2'd0:    res = {v[7], v[6:0], 1'b0};
        2'd1:    res = {v[7], v[6:0], cin};
        2'd2:    res = {v[0], 1'b0, v[7:1]};
        default: res = {v[0], cin, v[7:1]};
      endcase
      return res;
    end
  endfunction

  function automatic logic [7:0] status_of(input logic [FLAG_W-1:0] f);
    return {f[FL_N], f[FL_V], 1'b1, f[FL_B], f[FL_D], f[FL_I], f[FL_Z], f[FL_C]};
  endfunction

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    logic [2:0] aaa;
    logic [2:0] bbb;
    logic [1:0] cc;
    logic [7:0] nz_val;
    logic       nz_en;
    logic [7:0] addend;
    logic       do_add;
    logic [8:0] sum;
    logic [8:0] sh;
    logic [8:0] diff;
    logic [7:0] cmp_reg;
    logic       do_cmp;
    logic       fsel;

    aaa     = op_r[7:5];
    bbb     = op_r[4:2];
    cc      = op_r[1:0];
    acc_nxt = acc_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    sp_nxt  = sp_r;
    flag_nxt = flag_r;
    st      = '0;
    sv      = 1'b0;
    br      = 1'b0;
    nz_val  = '0;
    nz_en   = 1'b0;
    addend  = mem_r;
    do_add  = 1'b0;
    cmp_reg = acc_r;
    do_cmp  = 1'b0;
    fsel    = 1'b0;
    sh      = shift_op(aaa[1:0], (bbb == BBB_ACC) ? acc_r : mem_r, flag_r[FL_C]);

    if (op_r[4:0] == BRANCH_LO) begin
      case (aaa[2:1])
        2'd0:    fsel = flag_r[FL_N];
        2'd1:    fsel = flag_r[FL_V];
        2'd2:    fsel = flag_r[FL_C];
        default: fsel = flag_r[FL_Z];
      endcase
      br = (fsel == aaa[0]);
    end else begin
      unique case (op_r)
        OP_PHP: begin
          st = status_of(flag_r) | PUSH_BITS; sv = 1'b1; sp_nxt = sp_r - 8'd1;
        end
        OP_PHA: begin
          st = acc_r; sv = 1'b1; sp_nxt = sp_r - 8'd1;
        end
        OP_PLP: begin
          sp_nxt   = sp_r + 8'd1;
          flag_nxt = {mem_r[7:6], 1'b0, mem_r[3:0]};
        end
        OP_PLA: begin
          sp_nxt = sp_r + 8'd1; acc_nxt = mem_r; nz_val = mem_r; nz_en = 1'b1;
        end
        OP_DEY: begin y_nxt = y_r - 8'd1; nz_val = y_nxt; nz_en = 1'b1; end
        OP_INY: begin y_nxt = y_r + 8'd1; nz_val = y_nxt; nz_en = 1'b1; end
        OP_DEX: begin x_nxt = x_r - 8'd1; nz_val = x_nxt; nz_en = 1'b1; end
        OP_INX: begin x_nxt = x_r + 8'd1; nz_val = x_nxt; nz_en = 1'b1; end
        OP_TAY: begin y_nxt = acc_r; nz_val = acc_r; nz_en = 1'b1; end
        OP_TYA: begin acc_nxt = y_r; nz_val = y_r; nz_en = 1'b1; end
        OP_TAX: begin x_nxt = acc_r; nz_val = acc_r; nz_en = 1'b1; end
        OP_TXA: begin acc_nxt = x_r; nz_val = x_r; nz_en = 1'b1; end
        OP_TSX: begin x_nxt = sp_r; nz_val = sp_r; nz_en = 1'b1; end
        OP_TXS: sp_nxt = x_r;
        OP_CLC: flag_nxt[FL_C] = 1'b0;
        OP_SEC: flag_nxt[FL_C] = 1'b1;
        OP_CLI: flag_nxt[FL_I] = 1'b0;
        OP_SEI: flag_nxt[FL_I] = 1'b1;
        OP_CLV: flag_nxt[FL_V] = 1'b0;
        OP_CLD: flag_nxt[FL_D] = 1'b0;
        OP_SED: flag_nxt[FL_D] = 1'b1;
        default: begin
          if (cc == CC_1 && op_r != OP_BIT_IMM) begin
            case (aaa)
              G1_ORA: begin acc_nxt = acc_r | mem_r; nz_val = acc_nxt; nz_en = 1'b1; end
              G1_AND: begin acc_nxt = acc_r & mem_r; nz_val = acc_nxt; nz_en = 1'b1; end
              G1_EOR: begin acc_nxt = acc_r ^ mem_r; nz_val = acc_nxt; nz_en = 1'b1; end
              G1_ADC: do_add = 1'b1;
              G1_STA: begin st = acc_r; sv = 1'b1; end
              G1_LDA: begin acc_nxt = mem_r; nz_val = mem_r; nz_en = 1'b1; end
              G1_CMP: do_cmp = 1'b1;
              default: begin addend = ~mem_r; do_add = 1'b1; end
            endcase
          end else if (cc == CC_2) begin
            if (!aaa[2] && M_SHIFT[bbb]) begin
              flag_nxt[FL_C] = sh[8];
              nz_val = sh[7:0];
              nz_en  = 1'b1;
              if (bbb == BBB_ACC) begin
                acc_nxt = sh[7:0];
              end else begin
                st = sh[7:0]; sv = 1'b1;
              end
            end else if ((aaa == AAA_DEC || aaa == AAA_INC) && M_INCDEC[bbb]) begin
              st = (aaa == AAA_DEC) ? mem_r - 8'd1 : mem_r + 8'd1;
              sv = 1'b1; nz_val = st; nz_en = 1'b1;
            end else if (aaa == AAA_LD && M_LOAD[bbb]) begin
              x_nxt = mem_r; nz_val = mem_r; nz_en = 1'b1;
            end else if (aaa == AAA_ST && M_STORE[bbb]) begin
              st = x_r; sv = 1'b1;
            end
          end else if (cc == CC_0) begin
            if (aaa == AAA_BIT && M_BIT[bbb]) begin
              flag_nxt[FL_N] = mem_r[7];
              flag_nxt[FL_V] = mem_r[6];
              flag_nxt[FL_Z] = ((mem_r & acc_r) == 8'd0);
            end else if (aaa == AAA_DEC && M_CPXY[bbb]) begin
              cmp_reg = y_r; do_cmp = 1'b1;
            end else if (aaa == AAA_INC && M_CPXY[bbb]) begin
              cmp_reg = x_r; do_cmp = 1'b1;
            end else if (aaa == AAA_LD && M_LOAD[bbb]) begin
              y_nxt = mem_r; nz_val = mem_r; nz_en = 1'b1;
            end else if (aaa == AAA_ST && M_STORE[bbb]) begin
              st = y_r; sv = 1'b1;
            end
          end
        end
      endcase
    end

    sum  = {1'b0, acc_r} + {1'b0, addend} + {8'd0, flag_r[FL_C]};
    diff = {1'b0, cmp_reg} - {1'b0, mem_r};
    if (do_add) begin
      flag_nxt[FL_V] = ~(acc_r[7] ^ addend[7]) & (acc_r[7] ^ sum[7]);
      flag_nxt[FL_C] = sum[8];
      acc_nxt = sum[7:0];
      nz_val  = sum[7:0];
      nz_en   = 1'b1;
    end
    if (do_cmp) begin
      flag_nxt[FL_C] = ~diff[8];
      nz_val = diff[7:0];
      nz_en  = 1'b1;
    end
    if (nz_en) begin
      flag_nxt[FL_N] = nz_val[7];
      flag_nxt[FL_Z] = (nz_val == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      x_r         <= '0;
      y_r         <= '0;
      sp_r        <= SP_RESET;
      flag_r      <= FLAG_RESET;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
        x_r         <= x_nxt;
        y_r         <= y_nxt;
        sp_r        <= sp_nxt;
        flag_r      <= flag_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_tdata[7:0];
      mem_r <= in_tdata[15:8];
    end
    if (out_load) begin
      out_data_r <= {6'd0, br, sv, st, status_of(flag_nxt), sp_nxt, y_nxt, x_nxt, acc_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_status_bit5: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[37])
    else $error("status bit 5 clear in result beat");

  a_no_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[48]) |-> (out_tdata[47:40] == 8'd0))
    else $error("store data not zero without store");

  a_branch_no_side: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && op_r[4:0] == BRANCH_LO) |->
      (acc_nxt == acc_r && x_nxt == x_r && y_nxt == y_r && sp_nxt == sp_r &&
       flag_nxt == flag_r && !sv))
    else $error("branch changed architectural state");

  a_b_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !flag_r[FL_B])
    else $error("B flag held set");

  a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid)
    else $error("executed beat produced no result");
`endif

endmodule

[bench/tb_cpu6502_execute_unit.sv]
// Self-checking bench for the 6502 execute stage: directed table, random opcodes, predictor.
`timescale 1ns / 100ps

module tb_cpu6502_execute_unit;
  import c6502_pkg::*;

  localparam logic [7:0] OP_NOP     = 8'hEA;
  localparam logic [7:0] OP_BRK     = 8'h00;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_SBC_IMM = 8'hE9;
  localparam logic [7:0] OP_AND_IMM = 8'h29;
  localparam logic [7:0] OP_ORA_IMM = 8'h09;
  localparam logic [7:0] OP_EOR_IMM = 8'h49;
  localparam logic [7:0] OP_CMP_IMM = 8'hC9;
  localparam logic [7:0] OP_BIT_ZP  = 8'h24;
  localparam logic [7:0] OP_ASL_A   = 8'h0A;
  localparam logic [7:0] OP_ROR_ZP  = 8'h66;
  localparam logic [7:0] OP_INC_ZP  = 8'hE6;
  localparam logic [7:0] OP_DEC_ZP  = 8'hC6;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_BMI     = 8'h30;
  localparam logic [7:0] OP_BCS     = 8'hB0;

  localparam logic [2:0] SH_ASL  = 3'd0;
  localparam logic [2:0] SH_ROL  = 3'd1;
  localparam logic [2:0] SH_LSR  = 3'd2;
  localparam logic [2:0] SH_ROR  = 3'd3;
  localparam logic [2:0] AAA_CPY = AAA_DEC;
  localparam logic [2:0] AAA_CPX = AAA_INC;

  localparam int N_DIRECTED = 26;
  localparam int PHASE_ITEMS = 412;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] status;
    logic [7:0] store;
    logic       store_en;
    logic       branch;
  } exec_result_t;

  typedef struct packed {
    logic [7:0]   opcode;
    logic [7:0]   mem;
    logic         typed;
    exec_result_t want;
  } stim_row_t;

  localparam exec_result_t NO_RESULT = '0;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  cpu6502_execute_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // predicted architectural state
  logic [7:0]        acc_q;
  logic [7:0]        x_q;
  logic [7:0]        y_q;
  logic [7:0]        sp_q;
  logic [FLAG_W-1:0] flg;

  exec_result_t pending_results [$];
  int           mismatches = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  logic         hold_off = 1'b0;

  int    tx_idle [4] = '{0, 81, 0, 7};
  int    rx_stall [4] = '{0, 0, 81, 7};
  string field_names [8] = '{"acc_out", "x_out", "y_out", "sp_out", "status_out",
                             "store_data", "store_valid", "branch_taken"};

  stim_row_t dir_rows [N_DIRECTED] = '{
    '{OP_NOP,     8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFD, 8'h24, 8'h00, 1'b0, 1'b0}},
    '{OP_PHP,     8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFC, 8'h24, 8'h34, 1'b1, 1'b0}},
    '{OP_LDA_IMM, 8'hFF, 1'b1, '{8'hFF, 8'h00, 8'h00, 8'hFC, 8'hA4, 8'h00, 1'b0, 1'b0}},
    '{OP_ADC_IMM, 8'h01, 1'b0, NO_RESULT},
    '{OP_SED,     8'h00, 1'b0, NO_RESULT},
    '{OP_ADC_IMM, 8'h7F, 1'b0, NO_RESULT},
    '{OP_SBC_IMM, 8'h80, 1'b0, NO_RESULT},
    '{OP_CLD,     8'h00, 1'b0, NO_RESULT},
    '{OP_AND_IMM, 8'hF0, 1'b0, NO_RESULT},
    '{OP_ORA_IMM, 8'h0F, 1'b0, NO_RESULT},
    '{OP_EOR_IMM, 8'hFF, 1'b0, NO_RESULT},
    '{OP_CMP_IMM, 8'h00, 1'b0, NO_RESULT},
    '{OP_BIT_ZP,  8'hC0, 1'b0, NO_RESULT},
    '{OP_ASL_A,   8'h00, 1'b0, NO_RESULT},
    '{OP_ROR_ZP,  8'h01, 1'b0, NO_RESULT},
    '{OP_INC_ZP,  8'hFF, 1'b0, NO_RESULT},
    '{OP_DEC_ZP,  8'h00, 1'b0, NO_RESULT},
    '{OP_LDX_IMM, 8'hFF, 1'b0, NO_RESULT},
    '{OP_TXS,     8'h00, 1'b0, NO_RESULT},
    '{OP_PLA,     8'h80, 1'b0, NO_RESULT},
    '{OP_PHP,     8'h00, 1'b0, NO_RESULT},
    '{OP_PLP,     8'hFF, 1'b0, NO_RESULT},
    '{OP_BMI,     8'h00, 1'b0, NO_RESULT},
    '{OP_BCS,     8'h00, 1'b0, NO_RESULT},
    '{OP_BRK,     8'h12, 1'b0, NO_RESULT},
    '{OP_BIT_IMM, 8'h34, 1'b0, NO_RESULT}
  };

  function automatic logic [7:0] status_byte();
    return {flg[FL_N], flg[FL_V], 1'b1, flg[FL_B:0]};
  endfunction

  function automatic logic [7:0] upd_nz(input logic [7:0] v);
    flg[FL_N] = v[7];
    flg[FL_Z] = (v == 8'h00);
    return v;
  endfunction

  function automatic void add_with_carry(input logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, acc_q} + {1'b0, m} + {8'h00, flg[FL_C]};
    flg[FL_V] = ~(acc_q[7] ^ m[7]) & (acc_q[7] ^ sum[7]);
    flg[FL_C] = sum[8];
    acc_q = upd_nz(sum[7:0]);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] diff;
    diff = r - m;
    flg[FL_C] = (r >= m);
    void'(upd_nz(diff));
  endfunction

  function automatic logic [7:0] shift_rot(input logic [2:0] kind, input logic [7:0] v);
    logic       cin;
    logic [7:0] r;
    cin = flg[FL_C];
    case (kind)
      SH_ASL: r = {v[6:0], 1'b0};
      SH_ROL: r = {v[6:0], cin};
      SH_LSR: r = {1'b0, v[7:1]};
      default: r = {cin, v[7:1]};
    endcase
    flg[FL_C] = (kind <= SH_ROL) ? v[7] : v[0];
    return upd_nz(r);
  endfunction

  // one instruction against the predicted state
  function automatic exec_result_t execute_op(input logic [7:0] op, input logic [7:0] md);
    exec_result_t r;
    logic [2:0]   aaa;
    logic [2:0]   bbb;
    logic [1:0]   cc;
    logic [3:0]   br_flags;
    r = '0;
    aaa = op[7:5];
    bbb = op[4:2];
    cc = op[1:0];
    if (op[4:0] == BRANCH_LO) begin
      br_flags = {flg[FL_Z], flg[FL_C], flg[FL_V], flg[FL_N]};
      r.branch = (br_flags[aaa[2:1]] == aaa[0]);
    end else begin
      case (op)
        OP_PHP: begin
          r.store = status_byte() | PUSH_BITS;
          r.store_en = 1'b1;
          sp_q = sp_q - 8'd1;
        end
        OP_PHA: begin
          r.store = acc_q;
          r.store_en = 1'b1;
          sp_q = sp_q - 8'd1;
        end
        OP_PLP: begin
          sp_q = sp_q + 8'd1;
          flg = {md[7:6], 1'b0, md[3:0]};
        end
        OP_PLA: begin
          sp_q = sp_q + 8'd1;
          acc_q = upd_nz(md);
        end
        OP_DEY: y_q = upd_nz(y_q - 8'd1);
        OP_INY: y_q = upd_nz(y_q + 8'd1);
        OP_DEX: x_q = upd_nz(x_q - 8'd1);
        OP_INX: x_q = upd_nz(x_q + 8'd1);
        OP_TAY: y_q = upd_nz(acc_q);
        OP_TYA: acc_q = upd_nz(y_q);
        OP_TAX: x_q = upd_nz(acc_q);
        OP_TXA: acc_q = upd_nz(x_q);
        OP_TSX: x_q = upd_nz(sp_q);
        OP_TXS: sp_q = x_q;
        OP_CLC: flg[FL_C] = 1'b0;
        OP_SEC: flg[FL_C] = 1'b1;
        OP_CLI: flg[FL_I] = 1'b0;
        OP_SEI: flg[FL_I] = 1'b1;
        OP_CLV: flg[FL_V] = 1'b0;
        OP_CLD: flg[FL_D] = 1'b0;
        OP_SED: flg[FL_D] = 1'b1;
        default: begin
          if (cc == CC_1 && op != OP_BIT_IMM) begin
            case (aaa)
              G1_ORA: acc_q = upd_nz(acc_q | md);
              G1_AND: acc_q = upd_nz(acc_q & md);
              G1_EOR: acc_q = upd_nz(acc_q ^ md);
              G1_ADC: add_with_carry(md);
              G1_STA: begin
                r.store = acc_q;
                r.store_en = 1'b1;
              end
              G1_LDA: acc_q = upd_nz(md);
              G1_CMP: compare_reg(acc_q, md);
              default: add_with_carry(~md);
            endcase
          end else if (cc == CC_2) begin
            if (aaa <= SH_ROR && M_SHIFT[bbb]) begin
              if (bbb == BBB_ACC) begin
                acc_q = shift_rot(aaa, acc_q);
              end else begin
                r.store = shift_rot(aaa, md);
                r.store_en = 1'b1;
              end
            end else if (aaa >= AAA_DEC && M_INCDEC[bbb]) begin
              r.store = upd_nz((aaa == AAA_DEC) ? md - 8'd1 : md + 8'd1);
              r.store_en = 1'b1;
            end else if (aaa == AAA_LD && M_LOAD[bbb]) begin
              x_q = upd_nz(md);
            end else if (aaa == AAA_ST && M_STORE[bbb]) begin
              r.store = x_q;
              r.store_en = 1'b1;
            end
          end else if (cc == CC_0) begin
            if (aaa == AAA_BIT && M_BIT[bbb]) begin
              flg[FL_N] = md[7];
              flg[FL_V] = md[6];
              flg[FL_Z] = ((md & acc_q) == 8'h00);
            end else if (aaa == AAA_CPY && M_CPXY[bbb]) begin
              compare_reg(y_q, md);
            end else if (aaa == AAA_CPX && M_CPXY[bbb]) begin
              compare_reg(x_q, md);
            end else if (aaa == AAA_LD && M_LOAD[bbb]) begin
              y_q = upd_nz(md);
            end else if (aaa == AAA_ST && M_STORE[bbb]) begin
              r.store = y_q;
              r.store_en = 1'b1;
            end
          end
        end
      endcase
    end
    r.acc = acc_q;
    r.x = x_q;
    r.y = y_q;
    r.sp = sp_q;
    r.status = status_byte();
    return r;
  endfunction

  task automatic send_instr(input logic [7:0] op, input logic [7:0] md, input logic typed,
                            input exec_result_t typed_res);
    exec_result_t pred;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {md, op};
    do @(posedge clk); while (!in_tready);
    pred = execute_op(op, md);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic check_beat(input logic [OUT_W-1:0] beat);
    exec_result_t exp;
    logic [7:0]   want [8];
    logic [7:0]   seen [8];
    if (pending_results.size() == 0) begin
      mismatches++;
      $error("result beat with nothing pending: %h", beat);
    end else begin
      exp = pending_results.pop_front();
      want = '{exp.acc, exp.x, exp.y, exp.sp, exp.status, exp.store,
               {7'b0, exp.store_en}, {7'b0, exp.branch}};
      seen = '{beat[7:0], beat[15:8], beat[23:16], beat[31:24], beat[39:32], beat[47:40],
               {7'b0, beat[48]}, {7'b0, beat[49]}};
      for (int i = 0; i < 8; i++) begin
        if (want[i] !== seen[i]) begin
          mismatches++;
          $error("%s: expected %h, got %h", field_names[i], want[i], seen[i]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_beat(out_tdata);
    out_tready <= rst_n && !hold_off && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // long receiver hold-off while the sender keeps offering beats
  initial begin
    wait (rst_n);
    repeat (100) @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("cpu6502_execute_unit: mismatch");
    $finish;
  end

  initial begin
    acc_q = 8'h00;
    x_q = 8'h00;
    y_q = 8'h00;
    sp_q = SP_RESET;
    flg = FLAG_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++)
      send_instr(dir_rows[i].opcode, dir_rows[i].mem, dir_rows[i].typed, dir_rows[i].want);
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct = tx_idle[ph];
      rx_stall_pct = rx_stall[ph];
      repeat (PHASE_ITEMS)
        send_instr(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    end
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("cpu6502_execute_unit: match");
    end else begin
      $display("cpu6502_execute_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/c6502_pkg.sv
hw/rtl/cpu6502_execute_unit.sv
bench/tb_cpu6502_execute_unit.sv
